// File: design/cone_mesh_vertex_generator_defines.svh
// ----------------------------------------------------------------------------
// cone mesh vertex generator assertion macros
// shared concurrent assertion forms, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef CONE_MESH_VERTEX_GENERATOR_DEFINES_SVH
`define CONE_MESH_VERTEX_GENERATOR_DEFINES_SVH

// condition implies consequence in the same cycle
`define CMVG_ASSERT_SAME(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("cmvg assertion failed");

// condition implies consequence in the next cycle
`define CMVG_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("cmvg assertion failed");

`endif

// File: design/cmvg_pkg.sv
// ----------------------------------------------------------------------------
// cmvg_pkg
// types and constants shared by the cone mesh vertex generator
// ----------------------------------------------------------------------------
`default_nettype none

package cmvg_pkg;

    localparam int CFG_W     = 24;
    localparam int CNT_W     = 11;
    localparam int KIND_W    = 2;
    localparam int DIV_NUM_W = 43;
    localparam int DIV_Q_W   = 33;
    localparam int PROD_W    = 35;
    localparam int TEX_W     = 17;
    localparam int POS_W     = 25;
    localparam int NRM_W     = 16;
    localparam int TRIG_W    = 32;

    // vertex kinds
    localparam logic [KIND_W-1:0] KIND_SIDE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RIM    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CENTER = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_RADIUS = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_SLICES = 2'd2;
    localparam logic [1:0] CFG_STACKS = 2'd3;

    // cordic gain in q2.30 and arctangents in q0.32 turns
    localparam logic [29:0] CORDIC_GAIN = 30'd652032875;
    localparam int ATAN_N = 24;
    localparam logic [29:0] ATAN_TURNS [0:ATAN_N-1] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340247,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81
    };

    // classified request from the front end
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CNT_W-1:0]  slice;
        logic [CNT_W-1:0]  stack;
        logic [PROD_W-1:0] ring_num;
        logic [PROD_W-1:0] z_num;
    } vtx_req_t;

    // fields riding alongside the cordic
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TEX_W-1:0]  ts;
        logic [TEX_W-1:0]  tt;
        logic [CFG_W-1:0]  ring;
        logic [CFG_W-1:0]  zq;
    } cord_tag_t;

endpackage

`default_nettype wire

// File: design/cmvg_fifo.sv
// ----------------------------------------------------------------------------
// cmvg_fifo
// small register queue between the front end and the back end
// ----------------------------------------------------------------------------
`default_nettype none

module cmvg_fifo
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign rdata     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// File: design/cmvg_front.sv
// ----------------------------------------------------------------------------
// cmvg_front
// request intake: index clamping and numerator products
// ----------------------------------------------------------------------------
`default_nettype none

module cmvg_front
    import cmvg_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [KIND_W-1:0] in_kind,
    input  wire logic [CNT_W-1:0]  in_slice,
    input  wire logic [CNT_W-1:0]  in_stack,
    input  wire logic [CFG_W-1:0]  radius,
    input  wire logic [CFG_W-1:0]  height,
    input  wire logic [CNT_W-1:0]  slices,
    input  wire logic [CNT_W-1:0]  stacks,
    output logic                   req_valid,
    input  wire logic              req_ready,
    output vtx_req_t               req
);

    logic     valid_reg, valid_next;
    vtx_req_t req_reg, req_next;
    logic [CNT_W-1:0] sl_c, st_c, st_left;

    assign in_ready  = !valid_reg || req_ready;
    assign req_valid = valid_reg;
    assign req       = req_reg;

    always_comb
    begin
        sl_c    = (in_slice > slices) ? slices : in_slice;
        st_c    = (in_stack > stacks) ? stacks : in_stack;
        st_left = stacks - st_c;
        req_next.kind     = in_kind;
        req_next.slice    = sl_c;
        req_next.stack    = st_c;
        req_next.ring_num = PROD_W'(radius) * PROD_W'(st_left);
        req_next.z_num    = PROD_W'(height) * PROD_W'(st_c);
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (req_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg <= req_next;
        end
    end

endmodule

`default_nettype wire

// File: design/cmvg_div.sv
// ----------------------------------------------------------------------------
// cmvg_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module cmvg_div
    import cmvg_pkg::*;
#(
    parameter int TAG_W = 1
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic [DIV_NUM_W-1:0] in_num,
    input  wire logic [CNT_W-1:0]     in_den,
    input  wire logic [TAG_W-1:0]     in_tag,
    output logic                      out_valid,
    output logic [DIV_Q_W-1:0]        out_quo,
    output logic [TAG_W-1:0]          out_tag
);

    // quotient is known to fit in DIV_Q_W bits, so the upper numerator
    // bits start out as the partial remainder
    logic [CNT_W-1:0]   stg_rem [0:DIV_Q_W];
    logic [DIV_Q_W-1:0] stg_low [0:DIV_Q_W];
    logic [DIV_Q_W-1:0] stg_quo [0:DIV_Q_W];
    logic [CNT_W-1:0]   stg_den [0:DIV_Q_W];
    logic [TAG_W-1:0]   stg_tag [0:DIV_Q_W];
    logic               stg_vld [0:DIV_Q_W];

    logic [CNT_W-1:0]   rem_reg [1:DIV_Q_W];
    logic [DIV_Q_W-1:0] low_reg [1:DIV_Q_W];
    logic [DIV_Q_W-1:0] quo_reg [1:DIV_Q_W];
    logic [CNT_W-1:0]   den_reg [1:DIV_Q_W];
    logic [TAG_W-1:0]   tag_reg [1:DIV_Q_W];
    logic               vld_reg [1:DIV_Q_W];

    assign stg_rem[0] = CNT_W'(in_num >> DIV_Q_W);
    assign stg_low[0] = in_num[DIV_Q_W-1:0];
    assign stg_quo[0] = '0;
    assign stg_den[0] = in_den;
    assign stg_tag[0] = in_tag;
    assign stg_vld[0] = in_valid;

    genvar i;
    generate
        for (i = 0; i < DIV_Q_W; i++)
        begin : g_stage
            logic [CNT_W:0]   trial;
            logic [CNT_W:0]   diff;
            logic             ge;
            logic [CNT_W-1:0] rem_next;

            assign trial    = {stg_rem[i], stg_low[i][DIV_Q_W-1]};
            assign diff     = trial - {1'b0, stg_den[i]};
            assign ge       = (trial >= {1'b0, stg_den[i]});
            assign rem_next = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[i+1] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[i+1] <= stg_vld[i];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i+1] <= rem_next;
                    low_reg[i+1] <= {stg_low[i][DIV_Q_W-2:0], 1'b0};
                    quo_reg[i+1] <= {stg_quo[i][DIV_Q_W-2:0], ge};
                    den_reg[i+1] <= stg_den[i];
                    tag_reg[i+1] <= stg_tag[i];
                end
            end

            assign stg_rem[i+1] = rem_reg[i+1];
            assign stg_low[i+1] = low_reg[i+1];
            assign stg_quo[i+1] = quo_reg[i+1];
            assign stg_den[i+1] = den_reg[i+1];
            assign stg_tag[i+1] = tag_reg[i+1];
            assign stg_vld[i+1] = vld_reg[i+1];
        end
    endgenerate

    assign out_valid = stg_vld[DIV_Q_W];
    assign out_quo   = stg_quo[DIV_Q_W];
    assign out_tag   = stg_tag[DIV_Q_W];

endmodule

`default_nettype wire

// File: design/cmvg_cordic.sv
// ----------------------------------------------------------------------------
// cmvg_cordic
// pipelined rotation-mode cordic, turn fraction in, cosine and sine out
// ----------------------------------------------------------------------------
`default_nettype none

module cmvg_cordic
    import cmvg_pkg::*;
#(
    parameter int STEPS = 16,
    parameter int TAG_W = 1
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [31:0]       in_u,
    input  wire logic [TAG_W-1:0]  in_tag,
    output logic                   out_valid,
    output logic signed [TRIG_W-1:0] out_cos,
    output logic signed [TRIG_W-1:0] out_sin,
    output logic [TAG_W-1:0]       out_tag
);

    localparam int XW = 34;

    logic [32:0] u_bias;
    logic [2:0]  qn;
    logic [33:0] z_full;

    // nearest quarter turn plus a residual of at most an eighth
    assign u_bias = {1'b0, in_u} + (33'd1 << 29);
    assign qn     = u_bias[32:30];
    assign z_full = {2'b00, in_u} - {1'b0, qn, 30'd0};

    logic signed [XW-1:0] stg_x [0:STEPS];
    logic signed [XW-1:0] stg_y [0:STEPS];
    logic signed [31:0]   stg_z [0:STEPS];
    logic [1:0]           stg_q [0:STEPS];
    logic [TAG_W-1:0]     stg_tag [0:STEPS];
    logic                 stg_vld [0:STEPS];

    logic signed [XW-1:0] x_reg [1:STEPS];
    logic signed [XW-1:0] y_reg [1:STEPS];
    logic signed [31:0]   z_reg [1:STEPS];
    logic [1:0]           q_reg [1:STEPS];
    logic [TAG_W-1:0]     tag_reg [1:STEPS];
    logic                 vld_reg [1:STEPS];

    assign stg_x[0]   = XW'(CORDIC_GAIN);
    assign stg_y[0]   = '0;
    assign stg_z[0]   = z_full[31:0];
    assign stg_q[0]   = qn[1:0];
    assign stg_tag[0] = in_tag;
    assign stg_vld[0] = in_valid;

    genvar i;
    generate
        for (i = 0; i < STEPS; i++)
        begin : g_step
            logic signed [XW-1:0] dx;
            logic signed [XW-1:0] dy;
            logic signed [31:0]   ang;
            logic                 pos;

            assign dx  = stg_y[i] >>> i;
            assign dy  = stg_x[i] >>> i;
            assign ang = 32'(ATAN_TURNS[i]);
            assign pos = !stg_z[i][31];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[i+1] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[i+1] <= stg_vld[i];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[i+1]   <= pos ? stg_x[i] - dx : stg_x[i] + dx;
                    y_reg[i+1]   <= pos ? stg_y[i] + dy : stg_y[i] - dy;
                    z_reg[i+1]   <= pos ? stg_z[i] - ang : stg_z[i] + ang;
                    q_reg[i+1]   <= stg_q[i];
                    tag_reg[i+1] <= stg_tag[i];
                end
            end

            assign stg_x[i+1]   = x_reg[i+1];
            assign stg_y[i+1]   = y_reg[i+1];
            assign stg_z[i+1]   = z_reg[i+1];
            assign stg_q[i+1]   = q_reg[i+1];
            assign stg_tag[i+1] = tag_reg[i+1];
            assign stg_vld[i+1] = vld_reg[i+1];
        end
    endgenerate

    logic signed [XW-1:0] rx, ry, cx, cy;
    localparam logic signed [XW-1:0] ONE = XW'(1) <<< 30;

    always_comb
    begin
        rx = stg_x[STEPS];
        ry = stg_y[STEPS];
        unique case (stg_q[STEPS])
            2'd1:
            begin
                rx = -stg_y[STEPS];
                ry = stg_x[STEPS];
            end
            2'd2:
            begin
                rx = -stg_x[STEPS];
                ry = -stg_y[STEPS];
            end
            2'd3:
            begin
                rx = stg_y[STEPS];
                ry = -stg_x[STEPS];
            end
            2'd0:
            begin
                rx = stg_x[STEPS];
                ry = stg_y[STEPS];
            end
        endcase
        cx = (rx > ONE) ? ONE : ((rx < -ONE) ? -ONE : rx);
        cy = (ry > ONE) ? ONE : ((ry < -ONE) ? -ONE : ry);
    end

    logic                     vout_reg;
    logic signed [TRIG_W-1:0] cos_reg, sin_reg;
    logic [TAG_W-1:0]         tout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vout_reg <= 1'b0;
        end
        else if (en)
        begin
            vout_reg <= stg_vld[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg  <= cx[TRIG_W-1:0];
            sin_reg  <= cy[TRIG_W-1:0];
            tout_reg <= stg_tag[STEPS];
        end
    end

    assign out_valid = vout_reg;
    assign out_cos   = cos_reg;
    assign out_sin   = sin_reg;
    assign out_tag   = tout_reg;

endmodule

`default_nettype wire

// File: design/cone_mesh_vertex_generator.sv
// ----------------------------------------------------------------------------
// cone_mesh_vertex_generator
// position, normal and texture coordinates of one tessellated cone vertex
// ----------------------------------------------------------------------------
// Each request names a side-grid vertex, a bottom-rim vertex or the bottom
// center; the block returns that vertex in fixed point (positions q8.16,
// normals q1.14, texture q1.16). Throughput is one vertex per clock with
// the output taken every cycle. From request to result a vertex passes one
// front register, the queue, 33 stages of the bit-per-stage dividers that
// form the turn fraction and the ring, height and texture quotients,
// CORDIC_STEPS rotation stages plus one quadrant stage, one multiply stage
// and the output register. The back pipeline advances only when the output
// register is free or being taken, and the four-entry queue lets the front
// keep accepting meanwhile. The user must write configuration through
// cfg_wr_en / cfg_index / cfg_data only while no request is in flight; the
// block itself does not enforce this.
`default_nettype none

`include "cone_mesh_vertex_generator_defines.svh"

module cone_mesh_vertex_generator
    import cmvg_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // configuration write port
    input  wire logic         cfg_wr_en,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [23:0]  cfg_data,
    // request stream
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [23:0]  s_axis_tdata,   // slice_index[10:0], stack_index[21:11]
    input  wire logic [1:0]   s_axis_tuser,   // vertex_kind[1:0]
    // result stream
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [159:0]      m_axis_tdata    // pos_x[24:0], pos_y[49:25], pos_z[74:50],
                                              // norm_x[90:75], norm_y[106:91],
                                              // norm_z[122:107], tex_s[139:123],
                                              // tex_t[156:140]
);

    localparam int REQ_W  = $bits(vtx_req_t);
    localparam int CTAG_W = $bits(cord_tag_t);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] radius_reg, height_reg;
    logic [CNT_W-1:0] slices_reg, stacks_reg;
    logic [CNT_W-1:0] slices_n, stacks_n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 24'd65536;
            height_reg <= 24'd65536;
            slices_reg <= 11'd32;
            stacks_reg <= 11'd8;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_RADIUS: radius_reg <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                CFG_SLICES: slices_reg <= cfg_data[CNT_W-1:0];
                CFG_STACKS: stacks_reg <= cfg_data[CNT_W-1:0];
            endcase
        end
    end

    // a zero count behaves as one
    assign slices_n = (slices_reg == '0) ? CNT_W'(1) : slices_reg;
    assign stacks_n = (stacks_reg == '0) ? CNT_W'(1) : stacks_reg;

    // ------------------------------------------------------------------
    // front end and queue
    // ------------------------------------------------------------------
    logic     fr_valid, fq_full, fq_not_empty, fq_pop;
    vtx_req_t fr_req, fq_head;
    logic [REQ_W-1:0] fq_rdata;
    logic     adv;

    cmvg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_kind   (s_axis_tuser),
        .in_slice  (s_axis_tdata[10:0]),
        .in_stack  (s_axis_tdata[21:11]),
        .radius    (radius_reg),
        .height    (height_reg),
        .slices    (slices_n),
        .stacks    (stacks_n),
        .req_valid (fr_valid),
        .req_ready (!fq_full),
        .req       (fr_req)
    );

    cmvg_fifo #(
        .WIDTH (REQ_W),
        .DEPTH (4)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fr_valid),
        .wdata     (fr_req),
        .full      (fq_full),
        .pop       (fq_pop),
        .rdata     (fq_rdata),
        .not_empty (fq_not_empty)
    );

    assign fq_head = vtx_req_t'(fq_rdata);

    // the whole back pipeline moves when the output slot is free or taken
    logic out_valid_reg;
    assign adv    = !out_valid_reg || m_axis_tready;
    assign fq_pop = adv && fq_not_empty;

    // ------------------------------------------------------------------
    // dividers: turn fraction, stack texture, ring radius, side height
    // ------------------------------------------------------------------
    logic [DIV_NUM_W-1:0] num_u, num_t, num_r, num_z;
    logic                 du_valid;
    logic [DIV_Q_W-1:0]   du_q, dt_q, dr_q, dz_q;
    logic [KIND_W-1:0]    du_kind;

    assign num_u = {fq_head.slice, 32'd0};
    assign num_t = {16'd0, fq_head.stack, 16'd0};
    assign num_r = {8'd0, fq_head.ring_num};
    assign num_z = {8'd0, fq_head.z_num};

    cmvg_div #(.TAG_W(KIND_W)) u_div_turn (
        .clk (clk), .rst_n (rst_n), .en (adv),
        .in_valid (fq_not_empty), .in_num (num_u), .in_den (slices_n),
        .in_tag (fq_head.kind),
        .out_valid (du_valid), .out_quo (du_q), .out_tag (du_kind)
    );

    cmvg_div #(.TAG_W(1)) u_div_tex (
        .clk (clk), .rst_n (rst_n), .en (adv),
        .in_valid (fq_not_empty), .in_num (num_t), .in_den (stacks_n),
        .in_tag (1'b0),
        .out_valid (), .out_quo (dt_q), .out_tag ()
    );

    cmvg_div #(.TAG_W(1)) u_div_ring (
        .clk (clk), .rst_n (rst_n), .en (adv),
        .in_valid (fq_not_empty), .in_num (num_r), .in_den (stacks_n),
        .in_tag (1'b0),
        .out_valid (), .out_quo (dr_q), .out_tag ()
    );

    cmvg_div #(.TAG_W(1)) u_div_z (
        .clk (clk), .rst_n (rst_n), .en (adv),
        .in_valid (fq_not_empty), .in_num (num_z), .in_den (stacks_n),
        .in_tag (1'b0),
        .out_valid (), .out_quo (dz_q), .out_tag ()
    );

    // ------------------------------------------------------------------
    // cosine and sine of the slice angle
    // ------------------------------------------------------------------
    cord_tag_t ci_tag, co_tag;
    logic [CTAG_W-1:0] co_tag_bits;
    logic      co_valid;
    logic signed [TRIG_W-1:0] co_cos, co_sin;

    always_comb
    begin
        ci_tag.kind = du_kind;
        ci_tag.ts   = du_q[32:16];          // full turn gives one
        ci_tag.tt   = dt_q[TEX_W-1:0];
        ci_tag.ring = dr_q[CFG_W-1:0];
        ci_tag.zq   = dz_q[CFG_W-1:0];
    end

    cmvg_cordic #(
        .STEPS (CORDIC_STEPS),
        .TAG_W (CTAG_W)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (du_valid),
        .in_u      (du_q[31:0]),          // full turn wraps to zero
        .in_tag    (ci_tag),
        .out_valid (co_valid),
        .out_cos   (co_cos),
        .out_sin   (co_sin),
        .out_tag   (co_tag_bits)
    );

    assign co_tag = cord_tag_t'(co_tag_bits);

    // ------------------------------------------------------------------
    // multiply stage: length times cosine and sine
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]         len;
    logic signed [56:0]       prod_x, prod_y;
    logic                     mul_valid_reg;
    logic signed [56:0]       mul_px_reg, mul_py_reg;
    logic signed [TRIG_W-1:0] mul_cos_reg, mul_sin_reg;
    cord_tag_t                mul_tag_reg;

    // side vertices use the shrinking ring, rim vertices the full radius
    assign len    = (co_tag.kind == KIND_SIDE) ? co_tag.ring : radius_reg;
    assign prod_x = $signed({1'b0, len}) * co_cos;
    assign prod_y = $signed({1'b0, len}) * co_sin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            mul_valid_reg <= co_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mul_px_reg  <= prod_x;
            mul_py_reg  <= prod_y;
            mul_cos_reg <= co_cos;
            mul_sin_reg <= co_sin;
            mul_tag_reg <= co_tag;
        end
    end

    // ------------------------------------------------------------------
    // rounding and field selection into the output register
    // ------------------------------------------------------------------
    logic signed [56:0] px_sum, py_sum;
    logic [TRIG_W-1:0]  cos_b, sin_b;
    logic [NRM_W-1:0]   nq_c, nq_s;
    logic [32:0]        rim_s_sum, rim_t_sum;
    logic [POS_W-1:0]   half_ext, z_side;
    logic [POS_W-1:0]   px_n, py_n, pz_n;
    logic [NRM_W-1:0]   nx_n, ny_n, nz_n;
    logic [TEX_W-1:0]   ts_n, tt_n;

    assign px_sum    = mul_px_reg + (57'sd1 <<< 29);
    assign py_sum    = mul_py_reg + (57'sd1 <<< 29);
    assign cos_b     = mul_cos_reg + (32'd1 << 15);
    assign sin_b     = mul_sin_reg + (32'd1 << 15);
    assign nq_c      = cos_b[31:16];
    assign nq_s      = sin_b[31:16];
    assign rim_s_sum = (33'd1 << 30) - {mul_cos_reg[31], mul_cos_reg} + (33'd1 << 14);
    assign rim_t_sum = (33'd1 << 30) + {mul_sin_reg[31], mul_sin_reg} + (33'd1 << 14);
    assign half_ext  = {2'b00, height_reg[CFG_W-1:1]};
    assign z_side    = {1'b0, mul_tag_reg.zq} - half_ext;

    always_comb
    begin
        px_n = '0;
        py_n = '0;
        pz_n = '0 - half_ext;
        nx_n = '0;
        ny_n = '0;
        nz_n = 16'hC000;                    // straight down
        ts_n = 17'd32768;
        tt_n = 17'd32768;
        unique case (mul_tag_reg.kind)
            KIND_SIDE:
            begin
                px_n = px_sum[54:30];
                py_n = py_sum[54:30];
                pz_n = z_side;
                nx_n = '0 - nq_c;           // inward normal
                ny_n = '0 - nq_s;
                nz_n = '0;
                ts_n = mul_tag_reg.ts;
                tt_n = mul_tag_reg.tt;
            end
            KIND_RIM:
            begin
                px_n = px_sum[54:30];
                py_n = py_sum[54:30];
                ts_n = rim_s_sum[31:15];
                tt_n = rim_t_sum[31:15];
            end
            default:
            begin
                // center, and the unused kind answers as the center
                px_n = '0;
            end
        endcase
    end

    logic [POS_W-1:0] out_px_reg, out_py_reg, out_pz_reg;
    logic [NRM_W-1:0] out_nx_reg, out_ny_reg, out_nz_reg;
    logic [TEX_W-1:0] out_ts_reg, out_tt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && mul_valid_reg)
        begin
            out_px_reg <= px_n;
            out_py_reg <= py_n;
            out_pz_reg <= pz_n;
            out_nx_reg <= nx_n;
            out_ny_reg <= ny_n;
            out_nz_reg <= nz_n;
            out_ts_reg <= ts_n;
            out_tt_reg <= tt_n;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_tt_reg, out_ts_reg, out_nz_reg, out_ny_reg,
                            out_nx_reg, out_pz_reg, out_py_reg, out_px_reg};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a stalled result freezes the back pipeline
    `CMVG_ASSERT_SAME(a_stall_holds, clk, rst_n, m_axis_tvalid && !m_axis_tready, !adv)
    // a finished product reaches the output slot
    `CMVG_ASSERT_NEXT(a_mul_to_out, clk, rst_n, adv && mul_valid_reg, m_axis_tvalid)
    // texture coordinates never pass one
    `CMVG_ASSERT_SAME(a_tex_range, clk, rst_n, m_axis_tvalid,
                      out_ts_reg <= 17'd65536 && out_tt_reg <= 17'd65536)
    // z normal is either flat side or straight down
    `CMVG_ASSERT_SAME(a_norm_z, clk, rst_n, m_axis_tvalid,
                      out_nz_reg == 16'h0000 || out_nz_reg == 16'hC000)

endmodule

`default_nettype wire

// File: tb/sv/cone_mesh_vertex_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cone mesh vertex checker
// watches config writes and both streams, predicts each vertex, compares
// ----------------------------------------------------------------------------
module cone_mesh_vertex_checker
    import cmvg_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_wr_en,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [23:0]  cfg_data,
    input  wire logic         s_axis_tvalid,
    input  wire logic         s_axis_tready,
    input  wire logic [23:0]  s_axis_tdata,   // slice_index[10:0], stack_index[21:11]
    input  wire logic [1:0]   s_axis_tuser,   // vertex_kind[1:0]
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic [159:0] m_axis_tdata,   // pos x/y/z, norm x/y/z, tex s/t
    output int                fail_count,
    output int                pending
);

    localparam int STEPS = 16;

    logic [23:0]  radius_q;
    logic [23:0]  height_q;
    logic [10:0]  slices_q;
    logic [10:0]  stacks_q;
    logic [159:0] vertex_q[$];

    localparam int FLD_LSB [0:7] = '{0, 25, 50, 75, 91, 107, 123, 140};
    localparam int FLD_W   [0:7] = '{25, 25, 25, 16, 16, 16, 17, 17};
    localparam string FLD_NAME [0:7] = '{"pos_x", "pos_y", "pos_z", "norm_x",
                                         "norm_y", "norm_z", "tex_s", "tex_t"};

    // cos and sin in q2.30 of a q0.32 turn fraction
    function automatic void turn_trig(input longint unsigned u, output longint c,
                                      output longint s);
        longint unsigned qn;
        longint z, x, y, t, dx, dy;
        qn = (u + (64'd1 << 29)) >> 30;
        z = longint'(u) - longint'(qn << 30);
        x = longint'(CORDIC_GAIN);
        y = 0;
        for (int i = 0; i < STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= longint'(ATAN_TURNS[i]);
            end
            else
            begin
                x += dx; y -= dy; z += longint'(ATAN_TURNS[i]);
            end
        end
        case (qn[1:0])
            2'd1: begin t = x; x = -y; y = t; end
            2'd2: begin x = -x; y = -y; end
            2'd3: begin t = x; x = y; y = -t; end
            default: ;
        endcase
        if (x > (64'sd1 <<< 30)) x = 64'sd1 <<< 30;
        if (x < -(64'sd1 <<< 30)) x = -(64'sd1 <<< 30);
        if (y > (64'sd1 <<< 30)) y = 64'sd1 <<< 30;
        if (y < -(64'sd1 <<< 30)) y = -(64'sd1 <<< 30);
        c = x;
        s = y;
    endfunction

    function automatic logic [159:0] predict_vertex(input logic [1:0] kind,
                                                    input logic [10:0] sl_in,
                                                    input logic [10:0] st_in);
        longint unsigned slices, stacks, sl, st, ring;
        longint c, s, half, px, py, pz, nx, ny, nz, ts, tt;
        logic [24:0] bx, by, bz;
        logic [15:0] bnx, bny, bnz;
        logic [16:0] bts, btt;
        slices = (slices_q != 0) ? slices_q : 1;
        stacks = (stacks_q != 0) ? stacks_q : 1;
        sl = (sl_in > slices) ? slices : sl_in;
        st = (st_in > stacks) ? stacks : st_in;
        turn_trig(((sl << 32) / slices) & 64'hFFFF_FFFF, c, s);
        half = longint'(height_q >> 1);
        px = 0; py = 0; pz = -half; nx = 0; ny = 0; nz = -16384;
        ts = 32768; tt = 32768;
        if (kind == KIND_SIDE)
        begin
            ring = longint'(radius_q) * (stacks - st) / stacks;
            px = (longint'(ring) * c + (64'sd1 <<< 29)) >>> 30;
            py = (longint'(ring) * s + (64'sd1 <<< 29)) >>> 30;
            pz = longint'(st * height_q / stacks) - half;
            nx = -((c + (64'sd1 <<< 15)) >>> 16);
            ny = -((s + (64'sd1 <<< 15)) >>> 16);
            nz = 0;
            ts = longint'((sl << 16) / slices);
            tt = longint'((st << 16) / stacks);
        end
        else if (kind == KIND_RIM)
        begin
            px = (longint'(radius_q) * c + (64'sd1 <<< 29)) >>> 30;
            py = (longint'(radius_q) * s + (64'sd1 <<< 29)) >>> 30;
            ts = ((64'sd1 <<< 30) - c + (64'sd1 <<< 14)) >>> 15;
            tt = ((64'sd1 <<< 30) + s + (64'sd1 <<< 14)) >>> 15;
        end
        bx = px[24:0]; by = py[24:0]; bz = pz[24:0];
        bnx = nx[15:0]; bny = ny[15:0]; bnz = nz[15:0];
        bts = ts[16:0]; btt = tt[16:0];
        return {3'b000, btt, bts, bnz, bny, bnx, bz, by, bx};
    endfunction

    assign pending = vertex_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_q   <= 24'd65536;
            height_q   <= 24'd65536;
            slices_q   <= 11'd32;
            stacks_q   <= 11'd8;
            fail_count <= 0;
            vertex_q.delete();
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_RADIUS: radius_q <= cfg_data;
                    CFG_HEIGHT: height_q <= cfg_data;
                    CFG_SLICES: slices_q <= cfg_data[10:0];
                    CFG_STACKS: stacks_q <= cfg_data[10:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                vertex_q.push_back(predict_vertex(s_axis_tuser, s_axis_tdata[10:0],
                                                  s_axis_tdata[21:11]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (vertex_q.size() == 0)
                begin
                    $error("vertex result with nothing expected: %h", m_axis_tdata);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    logic [159:0] want;
                    int bad;
                    want = vertex_q.pop_front();
                    bad = 0;
                    for (int f = 0; f < 8; f++)
                    begin
                        if (((want ^ m_axis_tdata) >> FLD_LSB[f]) &
                            ((160'd1 << FLD_W[f]) - 1))
                        begin
                            $error("%s: expected %h actual %h", FLD_NAME[f],
                                   (want >> FLD_LSB[f]) & ((160'd1 << FLD_W[f]) - 1),
                                   (m_axis_tdata >> FLD_LSB[f]) &
                                   ((160'd1 << FLD_W[f]) - 1));
                            bad++;
                        end
                    end
                    if (bad != 0)
                        fail_count <= fail_count + 1;
                end
            end
        end
    end

endmodule

// File: tb/sv/cone_mesh_vertex_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cone mesh vertex generator testbench
// drives vertex requests over several cone settings with random gaps and
// output stalls; the checker predicts and compares every vertex
// ----------------------------------------------------------------------------
module cone_mesh_vertex_generator_tb;
    import cmvg_pkg::*;

    localparam int DRAIN_CYCLES = 64;
    localparam int WATCHDOG_MAX = 20000;

    logic         clk;
    logic         rst_n;
    logic         cfg_wr_en;
    logic [1:0]   cfg_index;
    logic [23:0]  cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [23:0]  s_axis_tdata;   // slice_index[10:0], stack_index[21:11]
    logic [1:0]   s_axis_tuser;   // vertex_kind[1:0]
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [159:0] m_axis_tdata;   // pos x/y/z, norm x/y/z, tex s/t
    int           fail_count;
    int           pending;
    bit           idle_en;
    int           stall_left;
    int           quiet_cycles;
    logic [10:0]  cur_slices;
    logic [10:0]  cur_stacks;

    cone_mesh_vertex_generator DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    cone_mesh_vertex_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // 2 ns clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // result side: random stall bursts while idling is on
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end
        else if (!idle_en)
            m_axis_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= int'($urandom_range(0, 15));
        end
        else
            m_axis_tready <= 1'b1;
    end

    // watchdog on cycles with no request or result accepted
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_MAX)
        begin
            $display("FAIL cone_mesh_vertex_generator");
            $finish;
        end
    end

    // one request, with an optional sender gap ahead of it
    task automatic send_vertex(input logic [1:0] kind, input logic [10:0] sl,
                               input logic [10:0] st);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {2'b00, st, sl};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    // stop sending and let every outstanding vertex come back
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_cone(input logic [23:0] r, input logic [23:0] h,
                            input logic [10:0] sl, input logic [10:0] st);
        write_reg(CFG_RADIUS, r);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_SLICES, {13'd0, sl});
        write_reg(CFG_STACKS, {13'd0, st});
        @(posedge clk);
        cur_slices = (sl == 0) ? 11'd1 : sl;
        cur_stacks = (st == 0) ? 11'd1 : st;
    endtask

    // mostly in-range grid vertices, some out-of-range indexes and unused kind
    task automatic random_vertices(input int count);
        logic [1:0]  kind;
        logic [10:0] sl;
        logic [10:0] st;
        for (int n = 0; n < count; n++)
        begin
            kind = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
            if ($urandom_range(0, 9) == 0)
            begin
                sl = 11'($urandom);
                st = 11'($urandom);
            end
            else
            begin
                sl = 11'($urandom_range(0, cur_slices));
                st = 11'($urandom_range(0, cur_stacks));
            end
            send_vertex(kind, sl, st);
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= CFG_RADIUS;
        cfg_data      <= 24'd0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 24'd0;
        s_axis_tuser  <= KIND_SIDE;
        idle_en       = 1'b1;
        quiet_cycles  = 0;
        cur_slices    = 11'd32;
        cur_stacks    = 11'd8;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, field extremes, every kind, clamping
        send_vertex(KIND_SIDE, 11'd0, 11'd0);
        send_vertex(KIND_SIDE, 11'd32, 11'd8);
        send_vertex(KIND_SIDE, 11'd8, 11'd4);
        send_vertex(KIND_SIDE, 11'd16, 11'd2);
        send_vertex(KIND_SIDE, 11'd24, 11'd7);
        send_vertex(KIND_SIDE, 11'h7FF, 11'h7FF);
        send_vertex(KIND_SIDE, 11'd5, 11'h400);
        send_vertex(KIND_RIM, 11'd0, 11'd0);
        send_vertex(KIND_RIM, 11'd8, 11'h7FF);
        send_vertex(KIND_RIM, 11'd20, 11'd3);
        send_vertex(KIND_RIM, 11'h7FF, 11'd0);
        send_vertex(KIND_CENTER, 11'd0, 11'd0);
        send_vertex(KIND_CENTER, 11'h7FF, 11'h7FF);
        send_vertex(2'd3, 11'd3, 11'd3);
        send_vertex(2'd3, 11'h7FF, 11'h7FF);
        drain();

        // largest cone, largest counts
        set_cone(24'hFFFFFF, 24'hFFFFFF, 11'd1024, 11'd1024);
        send_vertex(KIND_SIDE, 11'd0, 11'd0);
        send_vertex(KIND_SIDE, 11'd1023, 11'd1);
        send_vertex(KIND_SIDE, 11'd1024, 11'd1024);
        send_vertex(KIND_RIM, 11'd256, 11'd0);
        send_vertex(KIND_RIM, 11'd1024, 11'd0);
        random_vertices(200);
        drain();

        // smallest cone, single slice and stack
        set_cone(24'd0, 24'd1, 11'd1, 11'd1);
        send_vertex(KIND_SIDE, 11'd1, 11'd1);
        send_vertex(KIND_RIM, 11'd1, 11'd0);
        random_vertices(150);
        drain();

        // zero counts behave as one
        set_cone(24'h123456, 24'h0ABCDE, 11'd0, 11'd0);
        random_vertices(150);
        drain();

        // random settings, small counts mostly
        for (int p = 0; p < 5; p++)
        begin
            set_cone(24'($urandom), 24'($urandom_range(1, 24'hFFFFFF)),
                     (p == 2) ? 11'($urandom_range(1, 1024)) : 11'($urandom_range(1, 64)),
                     (p == 3) ? 11'($urandom_range(1, 1024)) : 11'($urandom_range(1, 32)));
            random_vertices(200);
            drain();
        end

        // last part without any idling
        idle_en = 1'b0;
        set_cone(24'h010000, 24'h020000, 11'd3, 11'd5);
        random_vertices(200);
        drain();

        if (fail_count == 0 && pending == 0)
            $display("PASS cone_mesh_vertex_generator");
        else
            $display("FAIL cone_mesh_vertex_generator");
        $finish;
    end

endmodule
